>>> hw/rtl/upeq_pkg.sv
package upeq_pkg;

	// Payload widths of the request and response channels
	localparam int EVENT_ID_W   = 6;
	localparam int PRIO_REQ_W   = 16;

	// Request type codes
	localparam logic REQ_SET  = 1'b0;
	localparam logic REQ_POLL = 1'b1;

	// Top-level sequencer states
	typedef enum logic {
		ST_IDLE,
		ST_INS
	} state_t;

	// Operation broadcast to every cell of the chain
	typedef enum logic [1:0] {
		OP_NOP,
		OP_DEL,
		OP_INS,
		OP_POP
	} cell_op_t;

	// Control bundle from the sequencer to the cells
	typedef struct packed {
		cell_op_t                op;
		logic [EVENT_ID_W-1:0]   id;
	} cell_ctl_t;

endpackage

>>> hw/rtl/upeq_if.sv
interface upeq_req_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic [upeq_pkg::EVENT_ID_W-1:0]   event_id;
	logic [upeq_pkg::PRIO_REQ_W-1:0]   priority_req;

	modport source (output valid, req_type, event_id, priority_req, input ready);
	modport sink   (input valid, req_type, event_id, priority_req, output ready);
endinterface

interface upeq_rsp_if;
	logic                              valid;
	logic                              ready;
	logic                              found;
	logic [upeq_pkg::EVENT_ID_W-1:0]   polled_id;

	modport source (output valid, found, polled_id, input ready);
	modport sink   (input valid, found, polled_id, output ready);
endinterface

>>> hw/rtl/upeq_cell.sv
module upeq_cell #(
	parameter int PRIO_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  upeq_pkg::cell_ctl_t               ctl,
	input  logic [PRIO_BITS-1:0]              new_prio,
	input  logic                              left_gt,
	input  logic                              left_valid,
	input  logic [upeq_pkg::EVENT_ID_W-1:0]   left_id,
	input  logic [PRIO_BITS-1:0]              left_prio,
	input  logic                              right_valid,
	input  logic [upeq_pkg::EVENT_ID_W-1:0]   right_id,
	input  logic [PRIO_BITS-1:0]              right_prio,
	input  logic                              del_here,
	output logic                              valid,
	output logic [upeq_pkg::EVENT_ID_W-1:0]   id,
	output logic [PRIO_BITS-1:0]              prio,
	output logic                              gt,
	output logic                              match
);

	logic                              valid_q;
	logic [upeq_pkg::EVENT_ID_W-1:0]   id_q;
	logic [PRIO_BITS-1:0]              prio_q;
	logic                              nxt_valid;
	logic [upeq_pkg::EVENT_ID_W-1:0]   nxt_id;
	logic [PRIO_BITS-1:0]              nxt_prio;

	// Order by priority, then smaller id first
	assign gt    = valid_q && ({prio_q, ~id_q} > {new_prio, ~ctl.id});
	assign match = valid_q && (id_q == ctl.id);

	// Select the next entry: hold, take new key, or shift from a neighbor
	always_comb begin
		nxt_valid = valid_q;
		nxt_id    = id_q;
		nxt_prio  = prio_q;
		case (ctl.op)
			upeq_pkg::OP_INS: begin
				if (!gt) begin
					if (left_gt) begin
						nxt_valid = 1'b1;
						nxt_id    = ctl.id;
						nxt_prio  = new_prio;
					end else begin
						nxt_valid = left_valid;
						nxt_id    = left_id;
						nxt_prio  = left_prio;
					end
				end
			end
			upeq_pkg::OP_DEL: begin
				if (del_here) begin
					nxt_valid = right_valid;
					nxt_id    = right_id;
					nxt_prio  = right_prio;
				end
			end
			upeq_pkg::OP_POP: begin
				nxt_valid = right_valid;
				nxt_id    = right_id;
				nxt_prio  = right_prio;
			end
			default: begin
				nxt_valid = valid_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= nxt_valid;
		end
	end

	always_ff @(posedge clk) begin
		id_q   <= nxt_id;
		prio_q <= nxt_prio;
	end

	assign valid = valid_q;
	assign id    = id_q;
	assign prio  = prio_q;

endmodule

>>> hw/rtl/updatable_priority_event_queue_core.sv
// Keyed max-priority event queue.
// Request channel (req): req_type selects set (0) or poll (1). A set writes
// event_id with priority_req, replacing the priority of an id already queued;
// it gives no response. A set with an id not below NUM_IDS is dropped.
// A poll removes the queued event of highest priority (smaller id on a tie)
// and returns it on the response channel (rsp) with found = 1; an empty queue
// returns found = 0 and polled_id = 0.
// Entries live in a sorted chain of NUM_IDS cells, best entry in cell 0.
// A set removes the old copy of the id in the accept cycle by shifting the
// tail of the chain one cell toward the head, and inserts the new key at its
// sorted place in the next cycle. In the accept cycle of a poll, cell 0 is
// loaded into the response register and the chain shifts toward the head.
// The response appears in the cycle after the poll is accepted.
// Reset empties the queue at once; no clearing pass is needed.
// While a response waits on a stalled receiver, no further request of either
// kind is accepted; input resumes in the cycle the pending response is taken.
module updatable_priority_event_queue_core #(
	parameter int NUM_IDS   = 64,
	parameter int PRIO_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	upeq_req_if.sink     req,
	upeq_rsp_if.source   rsp
);

	localparam int IDW = upeq_pkg::EVENT_ID_W;

	upeq_pkg::state_t     state_q;
	upeq_pkg::state_t     state_nxt;
	upeq_pkg::cell_ctl_t  ctl;

	logic                 req_acc;
	logic                 in_range;
	logic [PRIO_BITS-1:0] in_prio;
	logic [IDW-1:0]       key_id_q;
	logic [PRIO_BITS-1:0] key_prio_q;

	logic                 rsp_valid_q;
	logic                 found_q;
	logic [IDW-1:0]       polled_id_q;

	logic [NUM_IDS-1:0]   cell_valid;
	logic [IDW-1:0]       cell_id   [NUM_IDS];
	logic [PRIO_BITS-1:0] cell_prio [NUM_IDS];
	logic [NUM_IDS-1:0]   cell_gt;
	logic [NUM_IDS-1:0]   cell_match;
	logic [NUM_IDS-1:0]   del_here;

	// Fit the request priority to the stored width
	generate
		if (PRIO_BITS <= upeq_pkg::PRIO_REQ_W) begin : g_prio_cut
			assign in_prio = req.priority_req[PRIO_BITS-1:0];
		end else begin : g_prio_ext
			assign in_prio = PRIO_BITS'(req.priority_req);
		end
	endgenerate

	assign in_range = (32'(req.event_id) < NUM_IDS);
	assign req.ready = (state_q == upeq_pkg::ST_IDLE) && (!rsp_valid_q || rsp.ready);
	assign req_acc   = req.valid && req.ready;

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			upeq_pkg::ST_IDLE: begin
				if (req_acc && (req.req_type == upeq_pkg::REQ_SET) && in_range) begin
					state_nxt = upeq_pkg::ST_INS;
				end
			end
			upeq_pkg::ST_INS: begin
				state_nxt = upeq_pkg::ST_IDLE;
			end
			default: begin
				state_nxt = upeq_pkg::ST_IDLE;
			end
		endcase
	end

	// Drive the chain operation
	always_comb begin
		ctl.op = upeq_pkg::OP_NOP;
		ctl.id = req.event_id;
		case (state_q)
			upeq_pkg::ST_INS: begin
				ctl.op = upeq_pkg::OP_INS;
				ctl.id = key_id_q;
			end
			upeq_pkg::ST_IDLE: begin
				if (req_acc) begin
					if (req.req_type == upeq_pkg::REQ_POLL) begin
						ctl.op = upeq_pkg::OP_POP;
					end else if (in_range) begin
						ctl.op = upeq_pkg::OP_DEL;
					end
				end
			end
			default: begin
				ctl.op = upeq_pkg::OP_NOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= upeq_pkg::ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Hold the key of a set for the insert cycle
	always_ff @(posedge clk) begin
		if (req_acc) begin
			key_id_q   <= req.event_id;
			key_prio_q <= in_prio;
		end
	end

	// Response register: load on poll, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (req_acc && (req.req_type == upeq_pkg::REQ_POLL)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc && (req.req_type == upeq_pkg::REQ_POLL)) begin
			found_q     <= cell_valid[0];
			polled_id_q <= cell_valid[0] ? cell_id[0] : '0;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.found     = found_q;
	assign rsp.polled_id = polled_id_q;

	// Row of cells, best entry at index 0
	generate
		for (genvar i = 0; i < NUM_IDS; i++) begin : g_cell
			logic                 l_gt;
			logic                 l_valid;
			logic [IDW-1:0]       l_id;
			logic [PRIO_BITS-1:0] l_prio;
			logic                 r_valid;
			logic [IDW-1:0]       r_id;
			logic [PRIO_BITS-1:0] r_prio;

			// Cell i shifts on delete when the matching id sits at or before it
			assign del_here[i] = |cell_match[i:0];

			if (i == 0) begin : g_head
				assign l_gt    = 1'b1;
				assign l_valid = 1'b0;
				assign l_id    = '0;
				assign l_prio  = '0;
			end else begin : g_body
				assign l_gt    = cell_gt[i-1];
				assign l_valid = cell_valid[i-1];
				assign l_id    = cell_id[i-1];
				assign l_prio  = cell_prio[i-1];
			end

			if (i == NUM_IDS - 1) begin : g_tail
				assign r_valid = 1'b0;
				assign r_id    = '0;
				assign r_prio  = '0;
			end else begin : g_mid
				assign r_valid = cell_valid[i+1];
				assign r_id    = cell_id[i+1];
				assign r_prio  = cell_prio[i+1];
			end

			upeq_cell #(
				.PRIO_BITS (PRIO_BITS)
			) u_cell (
				.clk         (clk),
				.arst_n      (arst_n),
				.ctl         (ctl),
				.new_prio    (key_prio_q),
				.left_gt     (l_gt),
				.left_valid  (l_valid),
				.left_id     (l_id),
				.left_prio   (l_prio),
				.right_valid (r_valid),
				.right_id    (r_id),
				.right_prio  (r_prio),
				.del_here    (del_here[i]),
				.valid       (cell_valid[i]),
				.id          (cell_id[i]),
				.prio        (cell_prio[i]),
				.gt          (cell_gt[i]),
				.match       (cell_match[i])
			);
		end
	endgenerate

`ifndef SYNTHESIS
	// Valid entries stay packed at the head of the chain
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((cell_valid + NUM_IDS'(1)) & cell_valid) == '0)
		else $error("hole in cell chain");

	// The id of a set is queued at most once when its delete runs
	a_unique: assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.op == upeq_pkg::OP_DEL) |-> $onehot0(cell_match))
		else $error("duplicate id in cell chain");

	// A poll gives a response in the next cycle
	a_poll_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && (req.req_type == upeq_pkg::REQ_POLL)) |=> rsp.valid)
		else $error("poll without response");

	// No request is taken during the insert cycle
	a_ins_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == upeq_pkg::ST_INS) |-> !req.ready)
		else $error("request taken during insert");

	// An empty poll returns id zero
	a_empty_id: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.found) |-> (rsp.polled_id == '0))
		else $error("nonzero id on empty poll");
`endif

endmodule
